@@ rtl/core/query_key_value_extractor_assert.svh @@
`ifndef QUERY_KEY_VALUE_EXTRACTOR_ASSERT_SVH
`define QUERY_KEY_VALUE_EXTRACTOR_ASSERT_SVH

// Same-cycle implication, gated off while in reset.
`define QKV_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, gated off while in reset.
`define QKV_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/qkv_pkg.sv @@
package qkv_pkg;

  localparam logic [7:0] CH_PCT   = 8'h25;  // '%'
  localparam logic [7:0] CH_PLUS  = 8'h2B;  // '+'
  localparam logic [7:0] CH_EQ    = 8'h3D;  // '='
  localparam logic [7:0] CH_AMP   = 8'h26;  // '&'
  localparam logic [7:0] CH_SPACE = 8'h20;  // ' '

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_BYTES  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LENGTH = 2'd1;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [7:0] char_in;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] value_byte;
    logic       byte_valid;
    logic       value_end;
    logic       found;
    logic       bad_escape;
  } out_item_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] reg_index;
    logic [63:0]          wdata;
  } cfg_item_t;

  // Byte after classification by the front end
  typedef struct packed {
    logic [7:0] lit;      // literal byte, plus already mapped to space
    logic [3:0] nib;      // hex digit value when is_hex
    logic       is_hex;
    logic       is_pct;
    logic       is_amp;
    logic       is_eq;
    logic       last;
  } class_t;

  typedef enum logic [2:0] {
    MODE_KEY   = 3'b001,
    MODE_VALUE = 3'b010,
    MODE_DONE  = 3'b100
  } mode_t;

  typedef enum logic [2:0] {
    ESC_NONE = 3'b001,
    ESC_HI   = 3'b010,
    ESC_LO   = 3'b100
  } esc_t;

endpackage

@@ rtl/core/qkv_stream_if.sv @@
interface qkv_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/core/query_key_value_extractor.sv @@
// Query string key lookup. Bytes of a form-encoded query string enter on in_ch, one per
// cycle at full rate; the first segment whose decoded key (%XX escapes, '+' as space)
// equals the configured key has its value streamed out on out_ch one decoded byte per
// transaction, and one closing transaction with value_end flags found and bad_escape
// for every string (it may carry the final value byte). A classifier writes each byte
// into a two-entry queue; a scan engine consumes one queued byte per cycle whenever its
// result register is empty or being taken. A result passes the queue and the result
// register before out_ch offers it; stalls on out_ch back up through the queue to in_ch.
// Key registers (index 0 key bytes, index 1 key length) are written on cfg_ch, always
// ready; the user writes them only while no string is in flight; the block does not check.
module query_key_value_extractor import qkv_pkg::*; #(
  parameter int KEY_CHARS = 8
) (
  input logic          clk,
  input logic          rst_n,
  qkv_stream_if.sink   in_ch,
  qkv_stream_if.source out_ch,
  qkv_stream_if.sink   cfg_ch
);

  logic      q_full;
  logic      q_push;
  class_t    q_in;
  logic      q_pop;
  logic      q_head_valid;
  class_t    q_head;
  in_item_t  in_item;
  cfg_item_t cfg_item;
  out_item_t out_item;
  logic      out_valid;

  assign in_item      = in_ch.data;
  assign cfg_item     = cfg_ch.data;
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = out_valid;
  assign out_ch.data  = out_item;

  qkv_front u_front (
    .in_valid (in_ch.valid),
    .in_data  (in_item),
    .in_ready (in_ch.ready),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_in)
  );

  qkv_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_data  (q_in),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_data  (q_head)
  );

  qkv_back #(
    .KEY_CHARS (KEY_CHARS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_ch.valid),
    .cfg_data   (cfg_item),
    .head_valid (q_head_valid),
    .head       (q_head),
    .pop        (q_pop),
    .out_valid  (out_valid),
    .out_data   (out_item),
    .out_ready  (out_ch.ready)
  );

endmodule

@@ rtl/core/qkv_fifo.sv @@
`include "query_key_value_extractor_assert.svh"

module qkv_fifo import qkv_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  class_t push_data,
  output logic   full,
  input  logic   pop,
  output logic   head_valid,
  output class_t head_data
);

  class_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r;
  logic [QPTR_W-1:0]   rd_ptr_r;
  logic [QCNT_W-1:0]   count_r;

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    if (p == QPTR_W'(QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  assign full       = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_data  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  `QKV_ASSERT_IMP(a_no_pop_empty, clk, rst_n, pop, head_valid, "pop from empty queue")
  `QKV_ASSERT_IMP(a_no_push_full, clk, rst_n, push, !full, "push into full queue")
  `QKV_ASSERT_NXT(a_push_fills, clk, rst_n, push && !pop, count_r != '0, "queue lost a push")

endmodule

@@ rtl/core/qkv_front.sv @@
module qkv_front import qkv_pkg::*; (
  input  logic     in_valid,
  input  in_item_t in_data,
  output logic     in_ready,
  input  logic     q_full,
  output logic     q_push,
  output class_t   q_data
);

  logic [7:0] c;

  assign c        = in_data.char_in;
  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_data        = '0;
    q_data.lit    = (c == CH_PLUS) ? CH_SPACE : c;
    q_data.is_pct = (c == CH_PCT);
    q_data.is_amp = (c == CH_AMP);
    q_data.is_eq  = (c == CH_EQ);
    q_data.last   = in_data.last;
    if (c >= "0" && c <= "9") begin
      q_data.is_hex = 1'b1;
      q_data.nib    = 4'(c - "0");
    end else if (c >= "a" && c <= "f") begin
      q_data.is_hex = 1'b1;
      q_data.nib    = 4'(c - "a" + 8'd10);
    end else if (c >= "A" && c <= "F") begin
      q_data.is_hex = 1'b1;
      q_data.nib    = 4'(c - "A" + 8'd10);
    end
  end

endmodule

@@ rtl/core/qkv_back.sv @@
`include "query_key_value_extractor_assert.svh"

module qkv_back import qkv_pkg::*; #(
  parameter int KEY_CHARS = 8
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cfg_we,
  input  cfg_item_t cfg_data,
  input  logic      head_valid,
  input  class_t    head,
  output logic      pop,
  output logic      out_valid,
  output out_item_t out_data,
  input  logic      out_ready
);

  localparam int KPW = $clog2(KEY_CHARS + 1);
  localparam int KIW = (KEY_CHARS > 1) ? $clog2(KEY_CHARS) : 1;

  logic [7:0]     key_r [KEY_CHARS];
  logic [3:0]     len_r;
  logic [KPW-1:0] used_len;

  mode_t          mode_r, mode_nxt;
  esc_t           esc_r, esc_nxt;
  logic [KPW-1:0] kpos_r, kpos_nxt;
  logic           mism_r, mism_nxt;
  logic [3:0]     hinib_r, hinib_nxt;

  logic           out_valid_r;
  out_item_t      out_data_r;

  out_item_t      res;
  logic           emit;
  logic [7:0]     esc_byte;
  logic [7:0]     cmp_ch;
  logic [7:0]     key_byte;
  logic           cmp_ok;

  assign used_len = (int'(len_r) > KEY_CHARS) ? KPW'(KEY_CHARS) : KPW'(len_r);
  assign key_byte = key_r[kpos_r[KIW-1:0]];
  assign esc_byte = {hinib_r, head.nib};
  assign cmp_ch   = (esc_r == ESC_LO) ? esc_byte : head.lit;
  assign cmp_ok   = (kpos_r < used_len) && (key_byte == cmp_ch);

  assign pop       = head_valid && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    mode_nxt  = mode_r;
    esc_nxt   = esc_r;
    kpos_nxt  = kpos_r;
    mism_nxt  = mism_r;
    hinib_nxt = hinib_r;
    res       = '0;
    emit      = 1'b0;

    case (mode_r)
      MODE_KEY: begin
        if (mism_r) begin
          if (head.is_amp) begin
            kpos_nxt  = '0;
            mism_nxt  = 1'b0;
            esc_nxt   = ESC_NONE;
            hinib_nxt = '0;
          end
        end else if (esc_r == ESC_NONE) begin
          if (head.is_eq) begin
            if (kpos_r == used_len) begin
              mode_nxt = MODE_VALUE;
            end else begin
              mism_nxt = 1'b1;
            end
          end else if (head.is_amp) begin
            if (kpos_r == used_len) begin
              res.value_end = 1'b1;
              res.found     = 1'b1;
              emit          = 1'b1;
              mode_nxt      = MODE_DONE;
            end else begin
              kpos_nxt  = '0;
              mism_nxt  = 1'b0;
              hinib_nxt = '0;
            end
          end else if (head.is_pct) begin
            esc_nxt = ESC_HI;
          end else if (cmp_ok) begin
            kpos_nxt = kpos_r + 1'b1;
          end else begin
            mism_nxt = 1'b1;
          end
        end else if (head.is_amp) begin
          // terminator inside an escape: segment simply restarts
          kpos_nxt  = '0;
          mism_nxt  = 1'b0;
          esc_nxt   = ESC_NONE;
          hinib_nxt = '0;
        end else if (head.is_hex) begin
          if (esc_r == ESC_HI) begin
            hinib_nxt = head.nib;
            esc_nxt   = ESC_LO;
          end else begin
            esc_nxt = ESC_NONE;
            if (cmp_ok) begin
              kpos_nxt = kpos_r + 1'b1;
            end else begin
              mism_nxt = 1'b1;
            end
          end
        end else begin
          esc_nxt  = ESC_NONE;
          mism_nxt = 1'b1;
        end
      end
      MODE_VALUE: begin
        if (esc_r == ESC_NONE) begin
          if (head.is_amp) begin
            res.value_end = 1'b1;
            res.found     = 1'b1;
            emit          = 1'b1;
            mode_nxt      = MODE_DONE;
          end else if (head.is_pct) begin
            esc_nxt = ESC_HI;
          end else begin
            res.value_byte = head.lit;
            res.byte_valid = 1'b1;
            emit           = 1'b1;
          end
        end else if (head.is_hex) begin
          if (esc_r == ESC_HI) begin
            hinib_nxt = head.nib;
            esc_nxt   = ESC_LO;
          end else begin
            res.value_byte = esc_byte;
            res.byte_valid = 1'b1;
            emit           = 1'b1;
            esc_nxt        = ESC_NONE;
          end
        end else begin
          res.value_end  = 1'b1;
          res.found      = 1'b1;
          res.bad_escape = 1'b1;
          emit           = 1'b1;
          esc_nxt        = ESC_NONE;
          mode_nxt       = MODE_DONE;
        end
      end
      default: ;
    endcase

    // End of string closes the lookup and rearms for the next string
    if (head.last) begin
      if (!res.value_end) begin
        case (mode_nxt)
          MODE_KEY: begin
            res.value_end = 1'b1;
            res.found     = !mism_nxt && (esc_nxt == ESC_NONE) && (kpos_nxt == used_len);
            emit          = 1'b1;
          end
          MODE_VALUE: begin
            res.value_end  = 1'b1;
            res.found      = 1'b1;
            res.bad_escape = (esc_nxt != ESC_NONE);
            emit           = 1'b1;
          end
          default: ;
        endcase
      end
      mode_nxt  = MODE_KEY;
      esc_nxt   = ESC_NONE;
      kpos_nxt  = '0;
      mism_nxt  = 1'b0;
      hinib_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < KEY_CHARS; i++) begin
        key_r[i] <= '0;
      end
      len_r <= '0;
    end else if (cfg_we) begin
      case (cfg_data.reg_index)
        REG_KEY_BYTES: begin
          for (int i = 0; i < KEY_CHARS; i++) begin
            key_r[i] <= cfg_data.wdata[8*i +: 8];
          end
        end
        REG_KEY_LENGTH: len_r <= cfg_data.wdata[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_KEY;
      esc_r       <= ESC_NONE;
      kpos_r      <= '0;
      mism_r      <= 1'b0;
      hinib_r     <= '0;
      out_valid_r <= 1'b0;
    end else if (pop) begin
      mode_r      <= mode_nxt;
      esc_r       <= esc_nxt;
      kpos_r      <= kpos_nxt;
      mism_r      <= mism_nxt;
      hinib_r     <= hinib_nxt;
      out_valid_r <= emit;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_data_r <= res;
    end
  end

  `QKV_ASSERT_IMP(a_done_no_escape, clk, rst_n, mode_r == MODE_DONE, esc_r == ESC_NONE, "escape pending after lookup ended")
  `QKV_ASSERT_NXT(a_last_rearms, clk, rst_n, pop && head.last, mode_r == MODE_KEY && kpos_r == '0 && !mism_r, "state not rearmed after last byte")
  `QKV_ASSERT_IMP(a_flags_need_end, clk, rst_n, out_valid_r && !out_data_r.value_end, !out_data_r.found && !out_data_r.bad_escape && out_data_r.byte_valid, "flags set without end")

endmodule

@@ tb/sv/query_key_value_extractor_tb.sv @@
`timescale 1ns / 1ps

module query_key_value_extractor_tb;
  import qkv_pkg::*;

  localparam int KEY_N = 8;
  localparam int PHASE_ITEMS = 175;

  typedef enum {CHK_MODEL, CHK_NONE, CHK_GIVEN} row_check_t;

  typedef struct {
    logic [7:0] ch;
    logic       last;
    row_check_t chk;
    out_item_t  want;
  } dir_row_t;

  logic clk;
  logic rst_n;

  qkv_stream_if #(.T(in_item_t))  in_ch ();
  qkv_stream_if #(.T(out_item_t)) out_ch ();
  qkv_stream_if #(.T(cfg_item_t)) cfg_ch ();

  query_key_value_extractor #(.KEY_CHARS(KEY_N)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Lookup state mirrored from the block
  logic [63:0] key_q;
  logic [3:0]  klen_q;
  mode_t       scan_mode_q;
  esc_t        esc_q;
  logic [3:0]  kpos_q;
  logic        mism_q;
  logic [3:0]  hi_q;

  out_item_t  results_due[$];
  dir_row_t   dir_rows[$];
  logic [7:0] text_q[$];
  logic [7:0] alpha[9] = '{"a", "b", " ", "k", "+", "%", "=", "&", "Z"};

  int err_count = 0;
  int live_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  always #4 clk = ~clk;

  function automatic bit hex_value(input logic [7:0] c, output logic [3:0] nib);
    nib = '0;
    if (c >= "0" && c <= "9") begin
      nib = 4'(c - "0");
      return 1'b1;
    end
    if (c >= "a" && c <= "f") begin
      nib = 4'(c - "a" + 8'd10);
      return 1'b1;
    end
    if (c >= "A" && c <= "F") begin
      nib = 4'(c - "A" + 8'd10);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic int key_used();
    return (klen_q > KEY_N) ? KEY_N : int'(klen_q);
  endfunction

  function automatic bit key_done();
    return !mism_q && esc_q == ESC_NONE && kpos_q == key_used();
  endfunction

  function automatic void new_segment();
    kpos_q = '0;
    mism_q = 1'b0;
    esc_q  = ESC_NONE;
    hi_q   = '0;
  endfunction

  function automatic void match_char(input logic [7:0] ch);
    if (kpos_q < key_used() && key_q[8*kpos_q +: 8] == ch) kpos_q++;
    else mism_q = 1'b1;
  endfunction

  function automatic out_item_t closing(input logic fd, input logic be);
    out_item_t r;
    r = '0;
    r.value_end  = 1'b1;
    r.found      = fd;
    r.bad_escape = be;
    return r;
  endfunction

  // One byte through the key matcher / value decoder
  function automatic void scan_byte(input logic [7:0] c, input logic last,
                                    output bit emit, output out_item_t r);
    logic [3:0] nib;
    bit hex;
    r = '0;
    emit = 1'b0;
    hex = hex_value(c, nib);
    case (scan_mode_q)
      MODE_KEY: begin
        if (mism_q) begin
          if (c == CH_AMP) new_segment();
        end else if (esc_q == ESC_NONE) begin
          if (c == CH_EQ) begin
            if (key_done()) scan_mode_q = MODE_VALUE;
            else mism_q = 1'b1;
          end else if (c == CH_AMP) begin
            if (key_done()) begin
              r = closing(1'b1, 1'b0);
              emit = 1'b1;
              scan_mode_q = MODE_DONE;
            end else begin
              new_segment();
            end
          end else if (c == CH_PCT) begin
            esc_q = ESC_HI;
          end else begin
            match_char((c == CH_PLUS) ? CH_SPACE : c);
          end
        end else if (c == CH_AMP) begin
          new_segment();
        end else if (hex) begin
          if (esc_q == ESC_HI) begin
            hi_q = nib;
            esc_q = ESC_LO;
          end else begin
            esc_q = ESC_NONE;
            match_char({hi_q, nib});
          end
        end else begin
          esc_q = ESC_NONE;
          mism_q = 1'b1;
        end
      end
      MODE_VALUE: begin
        if (esc_q == ESC_NONE) begin
          if (c == CH_AMP) begin
            r = closing(1'b1, 1'b0);
            emit = 1'b1;
            scan_mode_q = MODE_DONE;
          end else if (c == CH_PCT) begin
            esc_q = ESC_HI;
          end else begin
            r.value_byte = (c == CH_PLUS) ? CH_SPACE : c;
            r.byte_valid = 1'b1;
            emit = 1'b1;
          end
        end else if (c != CH_AMP && hex) begin
          if (esc_q == ESC_HI) begin
            hi_q = nib;
            esc_q = ESC_LO;
          end else begin
            r.value_byte = {hi_q, nib};
            r.byte_valid = 1'b1;
            emit = 1'b1;
            esc_q = ESC_NONE;
          end
        end else begin
          // bad digit or terminator inside an escape cuts the value
          r = closing(1'b1, 1'b1);
          emit = 1'b1;
          esc_q = ESC_NONE;
          scan_mode_q = MODE_DONE;
        end
      end
      default: ;
    endcase
    if (last) begin
      if (!r.value_end) begin
        if (scan_mode_q == MODE_KEY) begin
          r.value_end = 1'b1;
          r.found = key_done();
          emit = 1'b1;
        end else if (scan_mode_q == MODE_VALUE) begin
          r.value_end = 1'b1;
          r.found = 1'b1;
          r.bad_escape = (esc_q != ESC_NONE);
          emit = 1'b1;
        end
      end
      scan_mode_q = MODE_KEY;
      new_segment();
    end
  endfunction

  function automatic dir_row_t mk_row(input logic [7:0] ch, input logic last,
                                      input row_check_t chk, input out_item_t want);
    dir_row_t d;
    d.ch = ch;
    d.last = last;
    d.chk = chk;
    d.want = want;
    return d;
  endfunction

  // String generation
  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 10) return "0" + n;
    return ($urandom_range(1) ? "A" : "a") + n - 8'd10;
  endfunction

  function automatic logic [7:0] non_hex();
    logic [7:0] c;
    logic [3:0] nib;
    do c = 8'($urandom_range(1, 255)); while (hex_value(c, nib));
    return c;
  endfunction

  function automatic void put_escaped(input logic [7:0] c);
    text_q.push_back(CH_PCT);
    text_q.push_back(hex_char(c[7:4]));
    text_q.push_back(hex_char(c[3:0]));
  endfunction

  function automatic void put_char(input logic [7:0] c);
    if (c == 8'h00 || c == CH_PCT || c == CH_AMP || c == CH_EQ || c == CH_PLUS ||
        $urandom_range(99) < 25)
      put_escaped(c);
    else if (c == CH_SPACE && $urandom_range(1))
      text_q.push_back(CH_PLUS);
    else
      text_q.push_back(c);
  endfunction

  function automatic void put_bad_escape();
    text_q.push_back(CH_PCT);
    case ($urandom_range(3))
      0: text_q.push_back(non_hex());
      1: begin
        text_q.push_back(hex_char(4'($urandom_range(15))));
        text_q.push_back(non_hex());
      end
      2: text_q.push_back(hex_char(4'($urandom_range(15))));  // truncated if a terminator follows
      default: ;
    endcase
  endfunction

  function automatic logic [7:0] any_char();
    return $urandom_range(1) ? alpha[$urandom_range(8)] : 8'($urandom_range(255));
  endfunction

  function automatic void gen_string();
    int used;
    int n;
    int j;
    used = key_used();
    text_q.delete();
    if ($urandom_range(9) == 0) begin
      repeat ($urandom_range(1, 10)) text_q.push_back(8'($urandom_range(1, 255)));
    end else begin
      for (int s = 0; s < $urandom_range(1, 4); s++) begin
        if (s > 0) text_q.push_back(CH_AMP);
        if ($urandom_range(9) == 0) text_q.push_back(CH_AMP);
        case ($urandom_range(9))
          0, 1, 2, 3, 4: for (int i = 0; i < used; i++) put_char(key_q[8*i +: 8]);
          5: begin
            if (used > 0 && $urandom_range(1)) begin
              n = $urandom_range(used - 1);
              for (int i = 0; i < n; i++) put_char(key_q[8*i +: 8]);
            end else begin
              for (int i = 0; i < used; i++) put_char(key_q[8*i +: 8]);
              put_char(any_char());
            end
          end
          6: begin
            if (used == 0) begin
              put_char(any_char());
            end else begin
              j = $urandom_range(used - 1);
              for (int i = 0; i < used; i++)
                put_char(i == j ? key_q[8*i +: 8] ^ (8'h01 << $urandom_range(7))
                                : key_q[8*i +: 8]);
            end
          end
          7: repeat ($urandom_range(1, 3)) put_char(any_char());
          8: begin
            n = (used > 0) ? $urandom_range(used) : 0;
            for (int i = 0; i < n; i++) put_char(key_q[8*i +: 8]);
            put_bad_escape();
          end
          default: ;
        endcase
        if ($urandom_range(9) < 8) begin
          text_q.push_back(CH_EQ);
          repeat ($urandom_range(6)) begin
            if ($urandom_range(19) == 0) put_bad_escape();
            else put_char(any_char());
          end
        end
      end
    end
    if (text_q.size() == 0) text_q.push_back(8'($urandom_range(1, 255)));
  endfunction

  function automatic logic [63:0] alpha_key();
    logic [63:0] k;
    for (int i = 0; i < 8; i++) k[8*i +: 8] = alpha[$urandom_range(8)];
    return k;
  endfunction

  // Driving
  task automatic send_byte(input logic [7:0] c, input logic last,
                           input row_check_t chk, input out_item_t want);
    bit emit;
    out_item_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= '{char_in: c, last: last};
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    live_count++;
    scan_byte(c, last, emit, r);
    if (chk == CHK_MODEL && emit) results_due.push_back(r);
    else if (chk == CHK_GIVEN) results_due.push_back(want);
  endtask

  task automatic write_key(input logic [63:0] kb, input logic [3:0] kl);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= '{reg_index: REG_KEY_BYTES, wdata: kb};
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    key_q = kb;
    cfg_ch.data <= '{reg_index: REG_KEY_LENGTH, wdata: 64'(kl)};
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    klen_q = kl;
    cfg_ch.valid <= 1'b0;
  endtask

  // Wait out the queued results, then the bytes that make none
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Result checking
  always @(posedge clk) begin
    out_item_t want;
    out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (results_due.size() == 0) begin
        err_count++;
        if (err_count <= 10)
          $display("unexpected result: byte=%h bv=%b end=%b found=%b bad=%b",
                   out_ch.data.value_byte, out_ch.data.byte_valid, out_ch.data.value_end,
                   out_ch.data.found, out_ch.data.bad_escape);
      end else begin
        want = results_due.pop_front();
        if (want.value_byte !== out_ch.data.value_byte ||
            want.byte_valid !== out_ch.data.byte_valid ||
            want.value_end !== out_ch.data.value_end ||
            want.found !== out_ch.data.found ||
            want.bad_escape !== out_ch.data.bad_escape) begin
          err_count++;
          if (err_count <= 10)
            $display("mismatch: exp byte=%h bv=%b end=%b found=%b bad=%b, got byte=%h bv=%b end=%b found=%b bad=%b",
                     want.value_byte, want.byte_valid, want.value_end, want.found,
                     want.bad_escape, out_ch.data.value_byte, out_ch.data.byte_valid,
                     out_ch.data.value_end, out_ch.data.found, out_ch.data.bad_escape);
        end
      end
    end
  end

  initial begin
    #2000000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    out_ch.ready = 1'b0;
    key_q = '0;
    klen_q = '0;
    scan_mode_q = MODE_KEY;
    new_segment();

    // key "k+": only an escaped plus matches the second character
    dir_rows.push_back(mk_row("%", 1'b0, CHK_MODEL, '0));
    dir_rows.push_back(mk_row("6", 1'b0, CHK_MODEL, '0));
    dir_rows.push_back(mk_row("B", 1'b0, CHK_MODEL, '0));
    dir_rows.push_back(mk_row("%", 1'b0, CHK_MODEL, '0));
    dir_rows.push_back(mk_row("2", 1'b0, CHK_MODEL, '0));
    dir_rows.push_back(mk_row("B", 1'b0, CHK_MODEL, '0));
    dir_rows.push_back(mk_row("=", 1'b0, CHK_MODEL, '0));
    dir_rows.push_back(mk_row("%", 1'b0, CHK_MODEL, '0));
    dir_rows.push_back(mk_row("F", 1'b0, CHK_MODEL, '0));
    dir_rows.push_back(mk_row("F", 1'b0, CHK_MODEL, '0));
    dir_rows.push_back(mk_row(8'h01, 1'b0, CHK_MODEL, '0));
    dir_rows.push_back(mk_row("%", 1'b0, CHK_MODEL, '0));
    dir_rows.push_back(mk_row("4", 1'b0, CHK_MODEL, '0));
    dir_rows.push_back(mk_row("g", 1'b0, CHK_GIVEN, closing(1'b1, 1'b1)));
    dir_rows.push_back(mk_row(8'hFF, 1'b1, CHK_NONE, '0));
    // empty segments, key ended by '&', trailing bytes ignored
    dir_rows.push_back(mk_row(CH_AMP, 1'b0, CHK_MODEL, '0));
    dir_rows.push_back(mk_row(CH_AMP, 1'b0, CHK_MODEL, '0));
    dir_rows.push_back(mk_row("k", 1'b0, CHK_MODEL, '0));
    dir_rows.push_back(mk_row("%", 1'b0, CHK_MODEL, '0));
    dir_rows.push_back(mk_row("2", 1'b0, CHK_MODEL, '0));
    dir_rows.push_back(mk_row("b", 1'b0, CHK_MODEL, '0));
    dir_rows.push_back(mk_row(CH_AMP, 1'b0, CHK_GIVEN, closing(1'b1, 1'b0)));
    dir_rows.push_back(mk_row("z", 1'b1, CHK_NONE, '0));
    // literal plus decodes to space, so not found
    dir_rows.push_back(mk_row("k", 1'b0, CHK_MODEL, '0));
    dir_rows.push_back(mk_row(CH_PLUS, 1'b1, CHK_GIVEN, closing(1'b0, 1'b0)));

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_key(64'h2B6B, 4'd2);
    foreach (dir_rows[i])
      send_byte(dir_rows[i].ch, dir_rows[i].last, dir_rows[i].chk, dir_rows[i].want);
    drain();

    for (int p = 0; p < 8; p++) begin
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 50; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 50; end
        default: begin send_idle_pct = 21; recv_stall_pct = 21; end
      endcase
      case (p)
        0: write_key('0, 4'd0);
        1: write_key('1, 4'd8);
        2: write_key(alpha_key(), 4'd15);
        3: write_key({$urandom, $urandom}, 4'($urandom_range(1, 8)));
        4: write_key(alpha_key(), 4'd1);
        5: write_key({$urandom, $urandom}, 4'($urandom_range(9, 14)));
        6: write_key(alpha_key(), 4'($urandom_range(0, 8)));
        default: write_key('1, 4'd3);
      endcase
      live_count = 0;
      while (live_count < PHASE_ITEMS) begin
        gen_string();
        foreach (text_q[i])
          send_byte(text_q[i], i == text_q.size() - 1, CHK_MODEL, '0);
      end
      drain();
    end

    if (err_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

@@ query_key_value_extractor.f @@
+incdir+rtl/core
rtl/core/qkv_pkg.sv
rtl/core/qkv_stream_if.sv
rtl/core/qkv_fifo.sv
rtl/core/qkv_front.sv
rtl/core/qkv_back.sv
rtl/core/query_key_value_extractor.sv
tb/sv/query_key_value_extractor_tb.sv
